@@ rtl/assert_macros.svh @@
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, checking suspended while reset is high
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked property, checked through reset as well
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/gcsa_pkg.sv @@
// constants and types for the ghost cell source address unit
package gcsa_pkg;

  localparam int IDX_W  = 8;
  localparam int COMP_W = 3;
  localparam int MODE_W = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_I_FIRST    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_I_LAST     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_J_FIRST    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_J_LAST     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_K_FIRST    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_K_LAST     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DIMENSIONS = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_FACE_MODES = 3'd7;

  // face modes
  localparam logic [MODE_W-1:0] MODE_OUTFLOW = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REFLECT = 2'd2;

  // component numbers that match each axis
  localparam logic [COMP_W-1:0] COMP_X1 = 3'd0;
  localparam logic [COMP_W-1:0] COMP_X2 = 3'd1;
  localparam logic [COMP_W-1:0] COMP_X3 = 3'd2;

  typedef struct packed {
    logic              enable;
    logic              outer;
    logic              flip;
    logic [MODE_W-1:0] mode;
    logic [IDX_W-1:0]  first;
    logic [IDX_W-1:0]  last;
  } face_cfg_t;

  typedef struct packed {
    logic             written;
    logic             toggle;
    logic [IDX_W-1:0] coord;
  } face_res_t;

endpackage

@@ rtl/gcsa_in_if.sv @@
// cell item channel
interface gcsa_in_if;
  logic                         valid;
  logic                         ready;
  logic [gcsa_pkg::IDX_W-1:0]   cell_i;
  logic [gcsa_pkg::IDX_W-1:0]   cell_j;
  logic [gcsa_pkg::IDX_W-1:0]   cell_k;
  logic [gcsa_pkg::COMP_W-1:0]  component;
  logic                         vector_field;

  modport source (output valid, cell_i, cell_j, cell_k, component, vector_field,
                  input ready);
  modport sink (input valid, cell_i, cell_j, cell_k, component, vector_field,
                output ready);
endinterface

@@ rtl/gcsa_out_if.sv @@
// source address result channel
interface gcsa_out_if;
  logic                       valid;
  logic                       ready;
  logic                       write_enable;
  logic [gcsa_pkg::IDX_W-1:0] src_i;
  logic [gcsa_pkg::IDX_W-1:0] src_j;
  logic [gcsa_pkg::IDX_W-1:0] src_k;
  logic                       negate;

  modport source (output valid, write_enable, src_i, src_j, src_k, negate,
                  input ready);
  modport sink (input valid, write_enable, src_i, src_j, src_k, negate,
                output ready);
endinterface

@@ rtl/gcsa_face.sv @@
// traces one coordinate back through one boundary face pass
module gcsa_face (
  input  logic [gcsa_pkg::IDX_W-1:0] coord,
  input  gcsa_pkg::face_cfg_t        cfg,
  output gcsa_pkg::face_res_t        res
);

  logic                       in_ghost;
  logic                       active;
  logic                       is_outflow;
  logic                       is_reflect;
  logic [gcsa_pkg::IDX_W+1:0] mirror;
  logic [gcsa_pkg::IDX_W-1:0] mirror_sat;
  logic [gcsa_pkg::IDX_W-1:0] edge_idx;

  assign in_ghost   = cfg.outer ? (coord > cfg.last) : (coord < cfg.first);
  assign is_outflow = (cfg.mode == gcsa_pkg::MODE_OUTFLOW);
  assign is_reflect = (cfg.mode == gcsa_pkg::MODE_REFLECT);
  assign active     = cfg.enable && in_ghost && (is_outflow || is_reflect);
  assign edge_idx   = cfg.outer ? cfg.last : cfg.first;

  // two's complement over two extra bits: top bit marks below zero, next bit above range
  always_comb begin
    if (cfg.outer) begin
      mirror = {1'b0, cfg.last, 1'b0} + (gcsa_pkg::IDX_W+2)'(1) - {2'b00, coord};
    end else begin
      mirror = {1'b0, cfg.first, 1'b0} - {2'b00, coord} - (gcsa_pkg::IDX_W+2)'(1);
    end
    if (mirror[gcsa_pkg::IDX_W+1]) begin
      mirror_sat = '0;
    end else if (mirror[gcsa_pkg::IDX_W]) begin
      mirror_sat = '1;
    end else begin
      mirror_sat = mirror[gcsa_pkg::IDX_W-1:0];
    end
  end

  assign res.written = active;
  assign res.toggle  = active && is_reflect && cfg.flip;
  assign res.coord   = !active ? coord : (is_outflow ? edge_idx : mirror_sat);

endmodule

@@ rtl/ghost_cell_source_address_unit.sv @@
// ghost cell source address unit: top level
//
// Usage: one item on the cells channel carries a cell coordinate, a component
// number and a vector flag; one item on the results channel answers it with the
// source cell whose value lands in that cell after the six boundary passes
// (inner then outer per axis, x1, x2, x3), a negate flag and a write flag.
// Both channels use valid/ready; an item moves when both are high.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data); the user
// must write it only while no item is in flight; the block does not check this.
// Path: an accepted item waits in the input register, passes the six face traces
// and is held in the result register, from which its result is shown.
// Throughput: one item per cycle while results.ready stays high; the traces are
// a single pass of compares and small adds between the two registers.
// Stall: when the receiver holds ready low the result register holds, one more
// item is taken into the input register, then cells.ready drops.
// Reset: both stages empty, interior ranges 0..255, one dimension, all faces off.
module ghost_cell_source_address_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [gcsa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gcsa_pkg::CFG_DATA_W-1:0]     cfg_data,
  gcsa_in_if.sink                             cells,
  gcsa_out_if.source                          results
);

  `include "assert_macros.svh"

  // configuration
  logic [gcsa_pkg::IDX_W-1:0]      i_first, i_last, j_first, j_last, k_first, k_last;
  logic [1:0]                      dimensions;
  logic [gcsa_pkg::CFG_DATA_W-1:0] face_modes;

  always_ff @(posedge clk) begin
    if (rst) begin
      i_first    <= '0;
      i_last     <= '1;
      j_first    <= '0;
      j_last     <= '1;
      k_first    <= '0;
      k_last     <= '1;
      dimensions <= 2'd1;
      face_modes <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        gcsa_pkg::CFG_I_FIRST:    i_first    <= cfg_data[gcsa_pkg::IDX_W-1:0];
        gcsa_pkg::CFG_I_LAST:     i_last     <= cfg_data[gcsa_pkg::IDX_W-1:0];
        gcsa_pkg::CFG_J_FIRST:    j_first    <= cfg_data[gcsa_pkg::IDX_W-1:0];
        gcsa_pkg::CFG_J_LAST:     j_last     <= cfg_data[gcsa_pkg::IDX_W-1:0];
        gcsa_pkg::CFG_K_FIRST:    k_first    <= cfg_data[gcsa_pkg::IDX_W-1:0];
        gcsa_pkg::CFG_K_LAST:     k_last     <= cfg_data[gcsa_pkg::IDX_W-1:0];
        gcsa_pkg::CFG_DIMENSIONS: dimensions <= cfg_data[1:0];
        gcsa_pkg::CFG_FACE_MODES: face_modes <= cfg_data;
        default: ;
      endcase
    end
  end

  // handshake
  logic s1_valid;
  logic o_valid;
  logic o_free;

  assign o_free        = !o_valid || results.ready;
  assign cells.ready   = !s1_valid || o_free;
  assign results.valid = o_valid;

  // input register
  logic [gcsa_pkg::IDX_W-1:0]  s1_i, s1_j, s1_k;
  logic [gcsa_pkg::COMP_W-1:0] s1_comp;
  logic                        s1_vec;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cells.ready) begin
      s1_valid <= cells.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cells.ready) begin
      s1_i    <= cells.cell_i;
      s1_j    <= cells.cell_j;
      s1_k    <= cells.cell_k;
      s1_comp <= cells.component;
      s1_vec  <= cells.vector_field;
    end
  end

  // face traces, last pass first
  gcsa_pkg::face_cfg_t fc_ko, fc_ki, fc_jo, fc_ji, fc_io, fc_ii;
  gcsa_pkg::face_res_t fr_ko, fr_ki, fr_jo, fr_ji, fr_io, fr_ii;
  logic                k_gate;
  logic                flip_i, flip_j, flip_k;
  logic                we_c, neg_c;

  assign flip_i = s1_vec && (s1_comp == gcsa_pkg::COMP_X1);
  assign flip_j = s1_vec && (s1_comp == gcsa_pkg::COMP_X2);
  assign flip_k = s1_vec && (s1_comp == gcsa_pkg::COMP_X3);

  assign fc_ko = '{enable: (dimensions == 2'd3), outer: 1'b1, flip: flip_k,
                   mode: face_modes[11:10], first: k_first, last: k_last};
  assign fc_ki = '{enable: (dimensions == 2'd3), outer: 1'b0, flip: flip_k,
                   mode: face_modes[9:8], first: k_first, last: k_last};

  gcsa_face u_face_ko (.coord(s1_k),        .cfg(fc_ko), .res(fr_ko));
  gcsa_face u_face_ki (.coord(fr_ko.coord), .cfg(fc_ki), .res(fr_ki));

  // axis one and two passes only see cells whose traced k is interior
  assign k_gate = (fr_ki.coord >= k_first) && (fr_ki.coord <= k_last);

  assign fc_jo = '{enable: k_gate && dimensions[1], outer: 1'b1, flip: flip_j,
                   mode: face_modes[7:6], first: j_first, last: j_last};
  assign fc_ji = '{enable: k_gate && dimensions[1], outer: 1'b0, flip: flip_j,
                   mode: face_modes[5:4], first: j_first, last: j_last};
  assign fc_io = '{enable: k_gate, outer: 1'b1, flip: flip_i,
                   mode: face_modes[3:2], first: i_first, last: i_last};
  assign fc_ii = '{enable: k_gate, outer: 1'b0, flip: flip_i,
                   mode: face_modes[1:0], first: i_first, last: i_last};

  gcsa_face u_face_jo (.coord(s1_j),        .cfg(fc_jo), .res(fr_jo));
  gcsa_face u_face_ji (.coord(fr_jo.coord), .cfg(fc_ji), .res(fr_ji));
  gcsa_face u_face_io (.coord(s1_i),        .cfg(fc_io), .res(fr_io));
  gcsa_face u_face_ii (.coord(fr_io.coord), .cfg(fc_ii), .res(fr_ii));

  assign we_c  = fr_ko.written || fr_ki.written || fr_jo.written ||
                 fr_ji.written || fr_io.written || fr_ii.written;
  assign neg_c = fr_ko.toggle ^ fr_ki.toggle ^ fr_jo.toggle ^
                 fr_ji.toggle ^ fr_io.toggle ^ fr_ii.toggle;

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (o_free) begin
      o_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (o_free) begin
      results.write_enable <= we_c;
      results.src_i        <= fr_ii.coord;
      results.src_j        <= fr_ji.coord;
      results.src_k        <= fr_ki.coord;
      results.negate       <= neg_c;
    end
  end

  `ASSERT_CLK(a_negate_needs_write,
              results.valid |-> (!results.negate || results.write_enable),
              "negate set on an item that writes nothing")
  `ASSERT_CLK(a_unwritten_is_self,
              (s1_valid && o_free && !we_c) |=>
                (results.src_i == $past(s1_i) && results.src_j == $past(s1_j) &&
                 results.src_k == $past(s1_k)),
              "unwritten cell does not point at itself")
  `ASSERT_ALWAYS(a_stall_only_when_full,
                 !cells.ready |-> (s1_valid && o_valid && !results.ready),
                 "input stalled with room in the pipe")

endmodule
